/* src/sst_pkg.sv */
// shared constants, types and helper functions of the span tracker
// depends on nothing; every other file of the block but sst_ram imports it
package sst_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned ADDR_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned EXT_SH    = DATA_W - VALUE_WIDTH;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_FINISH = 5'b10000
  } sst_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic insert;
    logic load_out;
  } sst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic scan_last;
    logic busy;
    logic out_free;
  } sst_stat_t;

  // keep the low VALUE_WIDTH bits and sign-extend them to the full word
  function automatic logic signed [DATA_W-1:0] widen(input logic [DATA_W-1:0] raw);
    logic signed [DATA_W-1:0] t;
    t = $signed(raw << EXT_SH);
    return t >>> EXT_SH;
  endfunction

endpackage

/* src/sst_value_if.sv */
// input channel of the span tracker: one number per word
// depends on sst_pkg
interface sst_value_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* src/sst_result_if.sv */
// result channel of the span tracker: one word per accepted number
// depends on sst_pkg
interface sst_result_if import sst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [CNT_OUT_W-1:0] count;
  logic                 span_valid;
  logic [DATA_W-1:0]    shortest_span;
  logic [DATA_W-1:0]    longest_span;

  modport source (output valid, output status, output count, output span_valid,
                  output shortest_span, output longest_span, input ready);
  modport sink   (input valid, input status, input count, input span_valid,
                  input shortest_span, input longest_span, output ready);
endinterface

/* src/sst_cfg_if.sv */
// configuration write channel of the span tracker: capacity register
// depends on sst_pkg
interface sst_cfg_if import sst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

/* src/bounded_set_span_tracker.sv */
// top level of the bounded set span tracker
// depends on sst_pkg, the three channel interfaces, sst_ctrl and sst_dp
//
// usage
// - value_ch_i carries one signed number per word; each accepted number is
//   added to the held set unless the set already holds min(capacity, 256)
//   numbers, in which case it is dropped and flagged with status 1
// - result_ch_o returns exactly one word per accepted number: status, count
//   after the number, span_valid (two or more held), the least distance
//   between any two held numbers and the largest minus the smallest
// - cfg_ch_i writes the capacity register; it is always ready and should be
//   written only while no number is in flight
// - a rejected number goes from acceptance straight to the result, a number
//   into an empty set passes the insert step first, and any other number
//   first sweeps the single read port of the store, once per number, to find
//   the closest held value and drains a two stage distance and minimum pipeline
// - one number is processed at a time; the next one is taken as soon as the
//   result sits in the output register, even if the receiver has not taken it
// - when the receiver stalls, the finished result holds in the output
//   register and the following number waits at the end of its own work
// - reset empties the set, sets the least gap to all ones and the capacity
//   to 256; the store itself needs no clearing, only held entries are read
module bounded_set_span_tracker import sst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sst_value_if.sink       value_ch_i,
  sst_result_if.source    result_ch_o,
  sst_cfg_if.sink         cfg_ch_i
);

  sst_cmd_t  cmd;
  sst_stat_t stat;
  logic      in_ready;

  // capacity writes are taken at any time
  assign cfg_ch_i.ready   = 1'b1;
  assign value_ch_i.ready = in_ready;

  // sequencer: idle, scan the store, drain the pipeline, insert, hand off
  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (value_ch_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, distance pipeline, span registers and output register
  sst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_ch_i.value),
    .cfg_we_i     (cfg_ch_i.valid),
    .cfg_data_i   (cfg_ch_i.capacity),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (result_ch_o.valid),
    .out_ready_i  (result_ch_o.ready),
    .status_o     (result_ch_o.status),
    .count_o      (result_ch_o.count),
    .span_valid_o (result_ch_o.span_valid),
    .shortest_o   (result_ch_o.shortest_span),
    .longest_o    (result_ch_o.longest_span)
  );

endmodule

/* src/sst_ram.sv */
// generic single write port, single read port memory with registered read
// no dependencies
module sst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sst_ctrl.sv */
// sequencer of the span tracker: accept, scan, insert, hand off result
// depends on sst_pkg
module sst_ctrl import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sst_stat_t stat_i,
  output sst_cmd_t  cmd_o
);

  sst_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.full) begin
            state_d = ST_FINISH;
          end else if (stat_i.cnt_zero) begin
            state_d = ST_INSERT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!stat_i.busy) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/sst_dp.sv */
// datapath of the span tracker: number store, nearest-distance scan,
// span registers, capacity register and result register
// depends on sst_pkg and sst_ram
module sst_dp import sst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [DATA_W-1:0]    value_i,
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  input  sst_cmd_t             cmd_i,
  output sst_stat_t            stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [CNT_OUT_W-1:0] count_o,
  output logic                 span_valid_o,
  output logic [DATA_W-1:0]    shortest_o,
  output logic [DATA_W-1:0]    longest_o
);

  logic [CAP_W-1:0]         cap_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DATA_W-1:0]        least_q;
  logic signed [DATA_W-1:0] min_q, max_q, v_q;
  logic [DATA_W-1:0]        near_q;
  logic [ADDR_W-1:0]        addr_q;
  logic                     rd_vld_q, diff_vld_q, rej_q;
  logic [DATA_W-1:0]        diff_q;

  logic                     out_valid_q, out_status_q, out_span_q;
  logic [CNT_OUT_W-1:0]     out_count_q;
  logic [DATA_W-1:0]        out_short_q, out_long_q;

  logic [LIM_W-1:0]         cap_ext, max_ext, limit;
  logic                     full;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W:0]   d_fwd, d_bwd;
  logic [DATA_W-1:0]        diff_d;
  logic                     span_ok;

  // capacity clipped to the store depth
  assign cap_ext = LIM_W'(cap_q);
  assign max_ext = LIM_W'(MAX_ENTRIES);
  assign limit   = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign full    = LIM_W'(cnt_q) >= limit;

  assign stat_o.full      = full;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.scan_last = (CNT_W'(addr_q) == (cnt_q - CNT_W'(1)));
  assign stat_o.busy      = rd_vld_q | diff_vld_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  sst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (v_q),
    .re_i    (cmd_i.scan_step),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // absolute distance between a stored number and the new one
  assign d_fwd  = $signed({rd_data[DATA_W-1], rd_data}) - $signed({v_q[DATA_W-1], v_q});
  assign d_bwd  = $signed({v_q[DATA_W-1], v_q}) - $signed({rd_data[DATA_W-1], rd_data});
  assign diff_d = d_fwd[DATA_W] ? d_bwd[DATA_W-1:0] : d_fwd[DATA_W-1:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      least_q     <= '1;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      diff_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        addr_q <= '0;
      end else if (cmd_i.scan_step) begin
        addr_q <= addr_q + ADDR_W'(1);
      end
      rd_vld_q   <= cmd_i.scan_step;
      diff_vld_q <= rd_vld_q;
      if (cmd_i.insert) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (near_q < least_q) begin
          least_q <= near_q;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q    <= widen(value_i);
      rej_q  <= full;
      near_q <= '1;
    end else if (diff_vld_q && (diff_q < near_q)) begin
      near_q <= diff_q;
    end
    if (rd_vld_q) begin
      diff_q <= diff_d;
    end
    if (cmd_i.insert) begin
      if (cnt_q == '0) begin
        min_q <= v_q;
        max_q <= v_q;
      end else begin
        if (v_q < min_q) begin
          min_q <= v_q;
        end
        if (v_q > max_q) begin
          max_q <= v_q;
        end
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= rej_q;
      out_count_q  <= CNT_OUT_W'(cnt_q);
      out_span_q   <= span_ok;
      out_short_q  <= span_ok ? least_q : '0;
      out_long_q   <= span_ok ? DATA_W'(max_q - min_q) : '0;
    end
  end

  assign span_ok = (cnt_q >= CNT_W'(2));

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign count_o      = out_count_q;
  assign span_valid_o = out_span_q;
  assign shortest_o   = out_short_q;
  assign longest_o    = out_long_q;

  // an insert never goes beyond the store depth
  a_insert_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (cnt_q < CNT_W'(MAX_ENTRIES)))
    else $error("insert into a full store");

  // the scan only reads entries that were written
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (CNT_W'(addr_q) < cnt_q))
    else $error("scan read past the held numbers");

  // every insert adds exactly one number
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("count did not advance on insert");

  // the least gap can never exceed the whole span
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_span_q) |-> (out_short_q <= out_long_q))
    else $error("shortest span above longest span");

endmodule

/* tb/sv/bounded_set_span_tracker_tb.sv */
`timescale 1ns / 100ps
// self-checking bench of the bounded set span tracker: numbers in, one span word out
// depends on sst_pkg, the three channel interfaces and bounded_set_span_tracker
module bounded_set_span_tracker_tb;
  import sst_pkg::*;

  // status codes of the result word
  localparam logic STORED   = 1'b0;
  localparam logic REJECTED = 1'b1;

  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // directed numbers plus the random ones, with slack
  localparam int unsigned TOTAL_ITEMS = 800;
  // worst item: full sweep of the store, longest gap on both sides, margin x3
  localparam int unsigned RUN_LIMIT = TOTAL_ITEMS * (MAX_ENTRIES + 6 + 2 * 14 + 4) * 3 + 1000;

  typedef struct packed {
    logic                 status;
    logic [CNT_OUT_W-1:0] count;
    logic                 span_valid;
    logic [DATA_W-1:0]    shortest_span;
    logic [DATA_W-1:0]    longest_span;
  } span_word_t;

  logic clk_i;
  logic rst_ni;

  sst_value_if  value_ch ();
  sst_result_if result_ch ();
  sst_cfg_if    cfg_ch ();

  bounded_set_span_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_ch_i  (value_ch),
    .result_ch_o (result_ch),
    .cfg_ch_i    (cfg_ch)
  );

  // 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // predictor state: the held set in ascending order, the running least gap and
  // the capacity as last written through the config channel
  logic signed [DATA_W-1:0] held_values [MAX_ENTRIES];
  int unsigned              held_count;
  logic [DATA_W-1:0]        least_gap;
  logic [CAP_W-1:0]         held_capacity;

  // numbers waiting for the driver and span words waiting for the dut
  logic [DATA_W-1:0] pending_values [$];
  span_word_t        span_expect [$];

  // handshakes seen at the last rising edge, read by the negedge drivers
  logic value_fire;
  logic result_fire;
  logic cfg_fire;

  int unsigned queued_total;
  int unsigned taken_total;
  int unsigned stored_total;
  int unsigned rejected_total;
  int unsigned cap_writes;
  int unsigned error_count;
  int unsigned cycle_count;

  int unsigned send_gap;
  int unsigned take_wait;
  bit          send_steady;
  bit          take_steady;

  // per-word wait in cycles; now and then a side flips into a stretch of no idling
  function automatic int unsigned draw_gap(inout bit steady);
    if ($urandom_range(0, 31) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, field, got, want);
    error_count++;
  endtask

  // place one number into the held set and build the span word it should produce
  function automatic span_word_t insert_and_measure(input logic [DATA_W-1:0] raw);
    span_word_t               w;
    logic signed [DATA_W-1:0] v;
    logic [DATA_W-1:0]        gap;
    int unsigned              limit;
    int unsigned              pos;
    v = raw;
    // sign-extend from the top used bit
    for (int b = VALUE_WIDTH; b < DATA_W; b++) v[b] = raw[VALUE_WIDTH-1];
    limit = (held_capacity < MAX_ENTRIES) ? held_capacity : MAX_ENTRIES;
    w = '0;
    if (held_count >= limit) begin
      // full, or capacity dropped under what is already held
      w.status = REJECTED;
      rejected_total++;
    end else begin
      w.status = STORED;
      stored_total++;
      // equal numbers go after the ones already held
      pos = 0;
      while (pos < held_count && held_values[pos] <= v) pos++;
      // only the two new neighbor gaps can lower the least gap;
      // the difference wraps into an exact unsigned value
      if (pos > 0) begin
        gap = v - held_values[pos-1];
        if (gap < least_gap) least_gap = gap;
      end
      if (pos < held_count) begin
        gap = held_values[pos] - v;
        if (gap < least_gap) least_gap = gap;
      end
      for (int i = int'(held_count); i > int'(pos); i--) held_values[i] = held_values[i-1];
      held_values[pos] = v;
      held_count++;
    end
    w.count = CNT_OUT_W'(held_count);
    // spans read as zero until two numbers are held
    if (held_count >= 2) begin
      w.span_valid    = 1'b1;
      w.shortest_span = least_gap;
      w.longest_span  = held_values[held_count-1] - held_values[0];
    end
    return w;
  endfunction

  // random number: mostly full range, some close to a held one; repeats and the
  // range ends only where duplicates are wanted
  function automatic logic [DATA_W-1:0] pick_value(input bit allow_repeat);
    int unsigned       mode;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] delta;
    mode  = $urandom_range(0, 99);
    base  = (held_count != 0) ? held_values[$urandom_range(0, held_count - 1)] : $urandom;
    delta = DATA_W'($urandom_range(1, 16));
    if (allow_repeat && mode < 10) return base;
    if (allow_repeat && mode < 20) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    if (mode < 40) return $urandom_range(0, 1) ? base + delta : base - delta;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // rising edge: record handshakes, check span words, run the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    value_fire  <= rst_ni && value_ch.valid && value_ch.ready;
    result_fire <= rst_ni && result_ch.valid && result_ch.ready;
    cfg_fire    <= rst_ni && cfg_ch.valid && cfg_ch.ready;
    cycle_count++;

    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (span_expect.size() == 0) begin
        report_mismatch("word with nothing expected, count", DATA_W'(result_ch.count), '0);
      end else begin
        span_word_t want;
        want = span_expect.pop_front();
        if (result_ch.status !== want.status)
          report_mismatch("status", DATA_W'(result_ch.status), DATA_W'(want.status));
        if (result_ch.count !== want.count)
          report_mismatch("count", DATA_W'(result_ch.count), DATA_W'(want.count));
        if (result_ch.span_valid !== want.span_valid)
          report_mismatch("span_valid", DATA_W'(result_ch.span_valid),
                          DATA_W'(want.span_valid));
        if (result_ch.shortest_span !== want.shortest_span)
          report_mismatch("shortest_span", result_ch.shortest_span, want.shortest_span);
        if (result_ch.longest_span !== want.longest_span)
          report_mismatch("longest_span", result_ch.longest_span, want.longest_span);
      end
    end

    if (rst_ni && value_ch.valid && value_ch.ready) begin
      span_expect = {span_expect, insert_and_measure(value_ch.value)};
      taken_total++;
    end

    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      held_capacity = cfg_ch.capacity;
      cap_writes++;
    end

    // watchdog, kept last in this block
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               span_expect.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // number driver: holds a word until taken, then waits its drawn gap
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (value_ch.valid && !value_fire) begin
      // word still offered, ready was low
    end else begin
      if (value_fire) send_gap = draw_gap(send_steady);
      if (send_gap == 0 && pending_values.size() != 0) begin
        value_ch.value <= pending_values.pop_front();
        value_ch.valid <= 1'b1;
      end else begin
        value_ch.valid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: after each taken word it stalls for a drawn number of cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (result_fire) take_wait = draw_gap(take_steady);
    if (take_wait == 0) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= 1'b0;
      take_wait--;
    end
  end

  task automatic send_value(input logic [DATA_W-1:0] v);
    pending_values = {pending_values, v};
    queued_total++;
  endtask

  // every queued number taken and answered: the block is idle
  task automatic wait_drained();
    while (taken_total != queued_total || span_expect.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(negedge clk_i);
    cfg_ch.capacity <= cap;
    cfg_ch.valid    <= 1'b1;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(input int unsigned n, input bit allow_repeat);
    repeat (n) send_value(pick_value(allow_repeat));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed corners first, then random phases at several capacities
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    value_ch.valid  = 1'b0;
    value_ch.value  = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = '0;
    value_fire      = 1'b0;
    result_fire     = 1'b0;
    cfg_fire        = 1'b0;
    held_count      = 0;
    least_gap       = '1;
    held_capacity   = CAP_RESET;
    queued_total    = 0;
    taken_total     = 0;
    stored_total    = 0;
    rejected_total  = 0;
    cap_writes      = 0;
    error_count     = 0;
    cycle_count     = 0;
    send_gap        = 0;
    take_wait       = 0;
    send_steady     = 1'b0;
    take_steady     = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // capacity zero: everything bounces, spans stay zero
    write_capacity(CAP_W'(0));
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value('0);
    send_value('1);

    // single slot: one stored, then full
    write_capacity(CAP_W'(1));
    send_value(VAL_MIN);
    send_value(VAL_MAX);

    // both range ends held: the only gap is far beyond the signed maximum
    write_capacity(CAP_W'(2));
    send_value(VAL_MAX);
    send_value('0);

    // fill between the ends, least gap down to one, then full again
    write_capacity(CAP_W'(5));
    send_value('0);
    send_value('1);
    send_value(VAL_MAX - 1);
    send_value(DATA_W'(32'h1234_5678));

    // capacity lowered under the held count: rejected from here on
    write_capacity(CAP_W'(3));
    send_value(DATA_W'(1));

    // random fill at a mid capacity, repeats kept out so the least gap moves
    write_capacity(CAP_W'($urandom_range(120, 180)));
    send_random(220, 1'b0);

    // capacity dropped under the held count again, random numbers with repeats
    wait_drained();
    write_capacity(CAP_W'($urandom_range(0, held_count - 1)));
    send_random(30, 1'b1);

    // raised again, repeats and range ends allowed
    write_capacity(CAP_W'($urandom_range(200, 240)));
    send_random(200, 1'b1);

    // all capacity bits set: the store itself is the limit
    write_capacity('1);
    send_random(300, 1'b1);

    wait_drained();
    // a stray word would still show up within one full sweep
    repeat (MAX_ENTRIES + 8) @(negedge clk_i);
    if (span_expect.size() != 0)
      report_mismatch("words never delivered", DATA_W'(span_expect.size()), '0);

    $display("ran %0d numbers through %0d capacity writes: %0d stored, %0d rejected",
             taken_total, cap_writes, stored_total, rejected_total);
    $display("set ended at %0d numbers with least gap %0h", held_count, least_gap);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
